FILE: src/les_pkg.sv
package les_pkg;

    localparam int COLOR_W          = 8;
    localparam int ELAPSED_W        = 11;
    localparam int RAMP_W           = 9;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 8;
    localparam int COLOR_FULL       = 255;
    localparam int BOOT_MS_DEFAULT  = 1000;
    localparam int PULSE_MS_DEFAULT = 150;

    localparam logic [ELAPSED_W-1:0]   ELAPSED_MAX      = '1;
    localparam logic [COLOR_W-1:0]     BRIGHTNESS_RESET = COLOR_W'(50);
    localparam logic [CFG_INDEX_W-1:0] CFG_LED_ENABLE   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS   = CFG_INDEX_W'(1);

    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_BOOT        = 3'd1,
        OP_PULSE       = 3'd2,
        OP_SET_STATIC  = 3'd3,
        OP_STOP_STATIC = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

endpackage

FILE: src/les_scale.sv
module les_scale
    import les_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rgb_t               in_color,
    input  logic [COLOR_W-1:0] brightness,
    output logic               m_valid,
    input  logic               m_ready,
    output rgb_t               m_color
);

    logic                 out_valid_reg;
    logic                 out_valid_next;
    rgb_t                 out_color_reg;
    rgb_t                 scaled;
    logic [2*COLOR_W-1:0] prod_red;
    logic [2*COLOR_W-1:0] prod_green;
    logic [2*COLOR_W-1:0] prod_blue;

    assign in_ready = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_color  = out_color_reg;

    // channel * brightness, keep the upper byte
    assign prod_red   = in_color.red * brightness;
    assign prod_green = in_color.green * brightness;
    assign prod_blue  = in_color.blue * brightness;

    always_comb begin
        scaled.red     = prod_red[2*COLOR_W-1:COLOR_W];
        scaled.green   = prod_green[2*COLOR_W-1:COLOR_W];
        scaled.blue    = prod_blue[2*COLOR_W-1:COLOR_W];
        out_valid_next = in_ready ? in_valid : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (in_valid && in_ready) begin
            out_color_reg <= scaled;
        end
    end

    a_black_stays_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && in_color == '0) |=> (m_valid && m_color == '0))
        else $error("black item came out non-black");

    a_scale_no_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (m_color.red <= $past(in_color.red)
            && m_color.green <= $past(in_color.green)
            && m_color.blue <= $past(in_color.blue)))
        else $error("scaled channel above its input");

endmodule

FILE: src/led_effect_sequencer.sv
// path: a result is registered in pre_color_reg and then in the les_scale output register
// throughput: one item per cycle while s_ready is high, set by the single-pass ramp and mode update
// items with no result are still accepted; input stalls only while both result
// registers are full and m_ready is low
// the ramp division by BOOT_MS or PULSE_MS is a running quotient and remainder
// reset (aresetn low, synchronous): mode idle, elapsed 0, static colour black,
// led_enable 1, brightness 50, no item in flight
module led_effect_sequencer
    import les_pkg::*;
#(
    parameter int BOOT_MS  = BOOT_MS_DEFAULT,
    parameter int PULSE_MS = PULSE_MS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             s_opcode,
    input  logic [COLOR_W-1:0]     s_color_red,
    input  logic [COLOR_W-1:0]     s_color_green,
    input  logic [COLOR_W-1:0]     s_color_blue,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COLOR_W-1:0]     m_led_red,
    output logic [COLOR_W-1:0]     m_led_green,
    output logic [COLOR_W-1:0]     m_led_blue,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_STATIC = 2'd1,
        MODE_BOOT   = 2'd2,
        MODE_PULSE  = 2'd3
    } mode_t;

    localparam logic [ELAPSED_W-1:0] BOOT_DIV  = ELAPSED_W'(BOOT_MS);
    localparam logic [ELAPSED_W-1:0] PULSE_DIV = ELAPSED_W'(PULSE_MS);
    localparam logic [RAMP_W-1:0]    BOOT_Q    = RAMP_W'(COLOR_FULL / BOOT_MS);
    localparam logic [ELAPSED_W-1:0] BOOT_R    = ELAPSED_W'(COLOR_FULL % BOOT_MS);
    localparam logic [RAMP_W-1:0]    PULSE_Q   = RAMP_W'(COLOR_FULL / PULSE_MS);
    localparam logic [ELAPSED_W-1:0] PULSE_R   = ELAPSED_W'(COLOR_FULL % PULSE_MS);
    localparam logic [COLOR_W-1:0]   FULL      = COLOR_W'(COLOR_FULL);

    logic                 enable_reg;
    logic [COLOR_W-1:0]   brightness_reg;
    mode_t                mode_reg,    mode_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    rgb_t                 static_reg,  static_next;
    logic [RAMP_W-1:0]    ramp_reg,    ramp_next;
    logic [ELAPSED_W-1:0] rem_reg,     rem_next;
    logic                 pre_valid_reg, pre_valid_next;
    rgb_t                 pre_color_reg;

    logic                 s_fire;
    logic                 pre_advance;
    logic                 scale_ready;
    rgb_t                 m_color;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [ELAPSED_W-1:0] div;
    logic [ELAPSED_W-1:0] div_rem;
    logic [RAMP_W-1:0]    div_quo;
    logic [ELAPSED_W:0]   rem_sum;
    logic                 rem_carry;
    logic [ELAPSED_W:0]   rem_wrap;
    logic [RAMP_W-1:0]    ramp_step;
    logic [COLOR_W-1:0]   ramp_val;
    logic                 limit_hit;
    logic                 emit;
    rgb_t                 emit_color;

    assign s_fire      = s_valid && s_ready;
    assign pre_advance = !pre_valid_reg || scale_ready;
    assign s_ready     = pre_advance;
    assign cfg_ready   = 1'b1;

    // running quotient and remainder of elapsed*255 by the effect length
    always_comb begin
        elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
        div       = (mode_reg == MODE_BOOT) ? BOOT_DIV : PULSE_DIV;
        div_quo   = (mode_reg == MODE_BOOT) ? BOOT_Q : PULSE_Q;
        div_rem   = (mode_reg == MODE_BOOT) ? BOOT_R : PULSE_R;
        rem_sum   = {1'b0, rem_reg} + {1'b0, div_rem};
        rem_carry = rem_sum >= {1'b0, div};
        rem_wrap  = rem_carry ? rem_sum - {1'b0, div} : rem_sum;
        ramp_step = ramp_reg + div_quo + RAMP_W'(rem_carry);
        ramp_val  = ramp_step[COLOR_W-1:0];
        limit_hit = elapsed_inc > div;
    end

    always_comb begin
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        static_next  = static_reg;
        ramp_next    = ramp_reg;
        rem_next     = rem_reg;
        emit         = 1'b0;
        emit_color   = '0;
        if (s_fire) begin
            case (s_opcode)
                OP_TICK: begin
                    elapsed_next = elapsed_inc;
                    case (mode_reg)
                        MODE_STATIC: begin
                            emit       = 1'b1;
                            emit_color = static_reg;
                        end
                        MODE_BOOT, MODE_PULSE: begin
                            emit = 1'b1;
                            if (limit_hit) begin
                                mode_next = MODE_IDLE;
                            end else begin
                                ramp_next = ramp_step;
                                rem_next  = rem_wrap[ELAPSED_W-1:0];
                                if (mode_reg == MODE_BOOT) begin
                                    emit_color.green = ramp_val;
                                    emit_color.blue  = FULL - ramp_val;
                                end else begin
                                    emit_color.red = FULL - ramp_val;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                OP_BOOT: begin
                    mode_next    = MODE_BOOT;
                    elapsed_next = '0;
                    ramp_next    = '0;
                    rem_next     = '0;
                end
                OP_PULSE: begin
                    if (enable_reg) begin
                        mode_next    = MODE_PULSE;
                        elapsed_next = '0;
                        ramp_next    = '0;
                        rem_next     = '0;
                    end
                end
                OP_SET_STATIC: begin
                    static_next = '{red: s_color_red, green: s_color_green,
                                    blue: s_color_blue};
                    mode_next   = MODE_STATIC;
                end
                OP_STOP_STATIC: begin
                    mode_next = MODE_IDLE;
                    emit      = 1'b1;
                end
                default: ;
            endcase
        end
        // disabled output is black unless booting
        if (!enable_reg && mode_next != MODE_BOOT) begin
            emit_color = '0;
        end
        pre_valid_next = pre_advance ? (s_fire && emit) : pre_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b1;
            brightness_reg <= BRIGHTNESS_RESET;
            mode_reg       <= MODE_IDLE;
            elapsed_reg    <= '0;
            static_reg     <= '0;
            ramp_reg       <= '0;
            rem_reg        <= '0;
            pre_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LED_ENABLE: enable_reg     <= cfg_data[0];
                    CFG_BRIGHTNESS: brightness_reg <= cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
            mode_reg      <= mode_next;
            elapsed_reg   <= elapsed_next;
            static_reg    <= static_next;
            ramp_reg      <= ramp_next;
            rem_reg       <= rem_next;
            pre_valid_reg <= pre_valid_next;
        end
        if (pre_advance && s_fire && emit) begin
            pre_color_reg <= emit_color;
        end
    end

    les_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (pre_valid_reg),
        .in_ready   (scale_ready),
        .in_color   (pre_color_reg),
        .brightness (brightness_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_color    (m_color)
    );

    assign m_led_red   = m_color.red;
    assign m_led_green = m_color.green;
    assign m_led_blue  = m_color.blue;

    a_boot_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_BOOT) |-> (elapsed_reg <= BOOT_DIV && rem_reg < BOOT_DIV))
        else $error("boot ramp ran past its length");

    a_pulse_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_PULSE) |-> (elapsed_reg <= PULSE_DIV && rem_reg < PULSE_DIV))
        else $error("pulse fade ran past its length");

    a_stop_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_opcode == OP_STOP_STATIC) |=>
            (pre_valid_reg && pre_color_reg == '0 && mode_reg == MODE_IDLE))
        else $error("stop item did not queue a black result");

    a_trigger_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_opcode == OP_BOOT) |=>
            (mode_reg == MODE_BOOT && elapsed_reg == '0 && ramp_reg == '0))
        else $error("boot trigger did not restart the ramp");

endmodule
